/* rtl/core/cor_pkg.sv */
// Package with the shared types and constants of the midpoint circle rasterizer.
`default_nettype none

package cor_pkg;

    localparam int COORD_BITS  = 10;
    localparam int PIX_BITS    = COORD_BITS + 2;
    localparam int DEC_BITS    = COORD_BITS + 4;
    localparam int COLOR_BITS  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int SYM_COUNT   = 8;
    localparam int SYM_BITS    = $clog2(SYM_COUNT);

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t               req_type;
        logic [COORD_BITS-1:0]   center_x;
        logic [COORD_BITS-1:0]   center_y;
        logic [COORD_BITS-1:0]   radius;
        logic [COLOR_BITS-1:0]   color;
    } req_item_t;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] pixel_x;
        logic signed [PIX_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0]      pixel_color;
        logic                       last_of_step;
        logic                       circle_done;
    } pix_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] walk_x;
        logic [COORD_BITS-1:0] walk_y;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
    } step_job_t;

    typedef struct packed {
        logic      valid;
        step_job_t job;
    } job_push_t;

    typedef struct packed {
        logic      valid;
        logic      full;
        step_job_t job;
    } job_head_t;

endpackage

`default_nettype wire

/* rtl/core/cor_front.sv */
// Front end: takes requests, holds the circle state and advances the octant walk.
`default_nettype none

module cor_front
    import cor_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    input  wire logic      queue_full,
    output job_push_t      push
);

    logic [COORD_BITS-1:0]      held_cx_reg, held_cx_next;
    logic [COORD_BITS-1:0]      held_cy_reg, held_cy_next;
    logic [COLOR_BITS-1:0]      held_color_reg, held_color_next;
    logic [COORD_BITS-1:0]      walk_x_reg, walk_x_next;
    logic [COORD_BITS-1:0]      walk_y_reg, walk_y_next;
    logic [DEC_BITS-1:0]        dec_reg, dec_next;
    logic                       active_reg, active_next;

    logic                       accept;
    logic signed [PIX_BITS-1:0] x_adv;
    logic signed [PIX_BITS-1:0] y_adv;
    logic [DEC_BITS-1:0]        x_ext;
    logic [DEC_BITS-1:0]        y_ext;
    logic [DEC_BITS-1:0]        dec_adv;
    logic                       done;

    assign req_stall = queue_full;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        x_ext = {{(DEC_BITS-COORD_BITS){1'b0}}, walk_x_reg};
        y_ext = {{(DEC_BITS-COORD_BITS){1'b0}}, walk_y_reg};
        x_adv = $signed({2'b00, walk_x_reg}) + PIX_BITS'(1);
        if (dec_reg[DEC_BITS-1])
        begin
            dec_adv = dec_reg + (x_ext << 2) + DEC_BITS'(6);
            y_adv   = $signed({2'b00, walk_y_reg});
        end
        else
        begin
            dec_adv = dec_reg + ((x_ext - y_ext) << 2) + DEC_BITS'(10);
            y_adv   = $signed({2'b00, walk_y_reg}) - PIX_BITS'(1);
        end
        done = x_adv > y_adv;
    end

    always_comb
    begin
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        held_color_next = held_color_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        dec_next        = dec_reg;
        active_next     = active_reg;
        push.valid      = 1'b0;
        push.job        = '{center_x: held_cx_reg, center_y: held_cy_reg,
                            walk_x: walk_x_reg, walk_y: walk_y_reg,
                            color: held_color_reg, done: done};
        if (accept)
        begin
            unique case (req.req_type)
                REQ_START:
                begin
                    held_cx_next    = req.center_x;
                    held_cy_next    = req.center_y;
                    held_color_next = req.color;
                    walk_x_next     = '0;
                    walk_y_next     = req.radius;
                    dec_next        = DEC_BITS'(3)
                                    - ({{(DEC_BITS-COORD_BITS){1'b0}}, req.radius} << 1);
                    active_next     = 1'b1;
                end
                REQ_STEP:
                begin
                    if (active_reg)
                    begin
                        push.valid  = 1'b1;
                        walk_x_next = x_adv[COORD_BITS-1:0];
                        walk_y_next = y_adv[COORD_BITS-1:0];
                        dec_next    = dec_adv;
                        active_next = !done;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cx_reg    <= '0;
            held_cy_reg    <= '0;
            held_color_reg <= '0;
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            dec_reg        <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            held_cx_reg    <= held_cx_next;
            held_cy_reg    <= held_cy_next;
            held_color_reg <= held_color_next;
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            dec_reg        <= dec_next;
            active_reg     <= active_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cor_queue.sv */
// Short job queue between the walk front end and the pixel back end.
`default_nettype none

module cor_queue
    import cor_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_push_t push,
    input  wire logic      pop,
    output job_head_t      head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    step_job_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign head.valid = count_reg != '0;
    assign head.full  = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign head.job   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !head.full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cor_back.sv */
// Back end: expands one walk point into its eight symmetric pixels, one per cycle while pix_stall is low.
`default_nettype none

module cor_back
    import cor_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_head_t head,
    output logic           pop,
    output logic           pix_valid,
    input  wire logic      pix_stall,
    output pix_item_t      pix
);

    step_job_t             job_reg, job_next;
    logic                  job_valid_reg, job_valid_next;
    logic [SYM_BITS-1:0]   sym_reg, sym_next;
    logic                  out_valid_reg, out_valid_next;
    pix_item_t             out_reg, out_next;

    logic                  load;
    logic                  last;
    logic [PIX_BITS-1:0]   a_ext;
    logic [PIX_BITS-1:0]   b_ext;
    logic [PIX_BITS-1:0]   cx_ext;
    logic [PIX_BITS-1:0]   cy_ext;

    assign load = job_valid_reg && (!out_valid_reg || !pix_stall);
    assign last = load && (sym_reg == SYM_BITS'(SYM_COUNT - 1));
    assign pop  = head.valid && (!job_valid_reg || last);

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    always_comb
    begin
        cx_ext = {2'b00, job_reg.center_x};
        cy_ext = {2'b00, job_reg.center_y};
        a_ext  = sym_reg[2] ? {2'b00, job_reg.walk_y} : {2'b00, job_reg.walk_x};
        b_ext  = sym_reg[2] ? {2'b00, job_reg.walk_x} : {2'b00, job_reg.walk_y};

        out_next                = out_reg;
        out_next.pixel_x        = $signed(sym_reg[0] ? cx_ext - a_ext : cx_ext + a_ext);
        out_next.pixel_y        = $signed(sym_reg[1] ? cy_ext - b_ext : cy_ext + b_ext);
        out_next.pixel_color    = job_reg.color;
        out_next.last_of_step   = last;
        out_next.circle_done    = last && job_reg.done;

        job_next       = pop ? head.job : job_reg;
        job_valid_next = pop ? 1'b1 : (last ? 1'b0 : job_valid_reg);

        if (pop && !job_valid_reg)
        begin
            sym_next = '0;
        end
        else if (load)
        begin
            sym_next = sym_reg + SYM_BITS'(1);
        end
        else
        begin
            sym_next = sym_reg;
        end

        out_valid_next = load ? 1'b1 : (out_valid_reg && pix_stall);
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            sym_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            sym_reg       <= sym_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/circle_octant_rasterizer.sv */
// Top level of the midpoint circle rasterizer.
`default_nettype none

// A start item latches center, radius and color and produces no pixel.
// Each step item while a circle is active yields eight pixels, one per cycle on the
// output register while pix_stall is low; the pixel expander in the back end
// produces them. Step items are accepted back to back, while the queue is not full,
// into a two-entry job queue; when the back end is free, a step goes from its queue
// slot into the back-end job register, and its first pixel into the output register.
// A step item with no active circle is accepted and dropped. The eighth pixel of
// each step carries last_of_step, and of the final step also circle_done.
module circle_octant_rasterizer
    import cor_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           pix_valid,
    input  wire logic      pix_stall,
    output pix_item_t      pix
);

    job_push_t push;
    job_head_t head;
    logic      pop;

    cor_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (head.full),
        .push       (push)
    );

    cor_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head)
    );

    cor_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule

`default_nettype wire
